[hdl/programmable_branch_target_table_macros.svh]
// assertion macros used by the branch target table back end
`ifndef PROGRAMMABLE_BRANCH_TARGET_TABLE_MACROS_SVH
`define PROGRAMMABLE_BRANCH_TARGET_TABLE_MACROS_SVH

// implication checked on every clock edge outside reset
`define PBT_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define PBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pbt_pkg.sv]
// types and constants of the branch target table
package pbt_pkg;

  localparam int unsigned IDX_W = 5;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned VER_W = 32;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned CNT_W = 7;
  localparam logic [CNT_W-1:0] QUEUE_LIMIT = 7'd63;
  localparam logic [CNT_W-1:0] MAX_APPEND = 7'd64;

  typedef enum logic [2:0] {
    REQ_SET_SRC  = 3'd0,
    REQ_SET_TGT  = 3'd1,
    REQ_SET_COND = 3'd2,
    REQ_QUERY    = 3'd3,
    REQ_CONSUME  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    COND_NONE  = 3'd0,
    COND_TAKEN = 3'd1,
    COND_LOOP  = 3'd2,
    COND_BITS  = 3'd3
  } cond_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TAKEN = 2'd1,
    KIND_LOOP  = 2'd2,
    KIND_BITS  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PRED_NOMATCH   = 2'd0,
    PRED_TAKEN     = 2'd1,
    PRED_NOT_TAKEN = 2'd2,
    PRED_EXHAUSTED = 2'd3
  } pred_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0]        req;
    logic              act;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        kind;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  n;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        pred;
    logic [IDX_W-1:0]  idx;
    logic [VER_W-1:0]  ver;
    logic [ADDR_W-1:0] tgt;
    logic              err;
  } res_t;

endpackage

[hdl/programmable_branch_target_table.sv]
// top level of the programmable branch target table
//
// Input channel: queue style, in_push / in_full. A transaction is one
// request (set source, set target, set condition, query or consume).
// Result channel: queue style, out_empty / out_pop. Every request gives
// exactly one result, in request order.
// Flow: an accepted request is written into the command queue, then
// passes the back end table step into the result queue, from which it
// can be popped. The back end handles one command per cycle while the
// result queue is not full, so the sustained rate is one transaction per cycle;
// it is set by the single read-modify-write of the entry table per cycle.
// A two-deep command queue and a two-deep result queue decouple the
// sides. When the receiver stops popping, the result queue fills, the
// back end stalls, the command queue fills and in_full rises.
// Reset (rst_n low, synchronous) clears every entry to invalid with zero
// version and empties both queues.
module programmable_branch_target_table
  import pbt_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 32,
  parameter int unsigned ADDR_BITS = 48,
  parameter int unsigned VERSION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_req_type,
  input  logic [4:0]  in_entry_index,
  input  logic        in_index_valid,
  input  logic [47:0] in_address,
  input  logic [2:0]  in_cond_kind,
  input  logic [63:0] in_cond_value,
  input  logic [6:0]  in_bit_count,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_prediction,
  output logic [4:0]  out_hit_index,
  output logic [31:0] out_hit_version,
  output logic [47:0] out_predicted_target,
  output logic        out_error
);

  logic cmd_valid, cmd_take;
  cmd_t cmd;
  res_t res;

  pbt_front #(.NUM_ENTRIES(NUM_ENTRIES), .ADDR_BITS(ADDR_BITS)) u_front (
    .clk, .rst_n,
    .push(in_push), .full(in_full),
    .in_req_type, .in_entry_index, .in_index_valid, .in_address,
    .in_cond_kind, .in_cond_value, .in_bit_count,
    .cmd_valid, .cmd_take, .cmd
  );

  pbt_back #(.NUM_ENTRIES(NUM_ENTRIES), .VERSION_BITS(VERSION_BITS)) u_back (
    .clk, .rst_n,
    .cmd_valid, .cmd_take, .cmd,
    .empty(out_empty), .pop(out_pop), .res
  );

  assign out_prediction = res.pred;
  assign out_hit_index = res.idx;
  assign out_hit_version = res.ver;
  assign out_predicted_target = res.tgt;
  assign out_error = res.err;

endmodule

[hdl/pbt_front.sv]
// front end: accepts requests, classifies them and queues commands
module pbt_front
  import pbt_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 32,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        in_req_type,
  input  logic [4:0]        in_entry_index,
  input  logic              in_index_valid,
  input  logic [47:0]       in_address,
  input  logic [2:0]        in_cond_kind,
  input  logic [63:0]       in_cond_value,
  input  logic [6:0]        in_bit_count,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output cmd_t              cmd
);

  localparam int unsigned QD = 2;

  cmd_t q_r [QD];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  cmd_t       c;
  logic       in_range;
  logic       acc;

  // classify the incoming transaction
  always_comb begin
    in_range = ({4'd0, in_entry_index} < 9'(NUM_ENTRIES));
    c.req = in_req_type;
    c.idx = in_entry_index;
    c.addr = in_address & ((ADDR_BITS >= 48) ? {48{1'b1}} :
             ((48'd1 << ADDR_BITS) - 48'd1));
    c.kind = in_cond_kind;
    c.value = in_cond_value;
    c.n = in_bit_count;
    case (in_req_type)
      REQ_CONSUME: c.act = in_range & in_index_valid;
      REQ_QUERY:   c.act = 1'b1;
      default:     c.act = in_range;
    endcase
  end

  assign full = (cnt_r == 2'(QD));
  assign acc = push & ~full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rd_r];

  // queue pointers
  always_comb begin
    wr_nxt = wr_r ^ acc;
    rd_nxt = rd_r ^ (cmd_take & cmd_valid);
    cnt_nxt = cnt_r + {1'b0, acc} - {1'b0, cmd_take & cmd_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (acc) q_r[wr_r] <= c;
  end

endmodule

[hdl/pbt_back.sv]
// back end: entry table, query search and result queue
module pbt_back
  import pbt_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 32,
  parameter int unsigned VERSION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_take,
  input  cmd_t        cmd,
  output logic        empty,
  input  logic        pop,
  output res_t        res
);

  `include "programmable_branch_target_table_macros.svh"

  localparam int unsigned NE = NUM_ENTRIES;

  logic [ADDR_W-1:0]       src_r [NE];
  logic [ADDR_W-1:0]       tgt_r [NE];
  kind_t                   kind_r [NE];
  logic [VAL_W-1:0]        val_r [NE];
  logic [CNT_W-1:0]        bc_r [NE];
  logic [VERSION_BITS-1:0] ver_r [NE];

  res_t   oq_r [2];
  logic [1:0] ocnt_r;
  logic   ord_r, owr_r;
  logic   ofull;
  logic   go;
  logic [IDX_W-1:0] e;
  res_t   r;

  // per-entry update decisions
  logic        upd;
  logic        wr_src, wr_tgt;
  kind_t       nk;
  logic [VAL_W-1:0] nv;
  logic [CNT_W-1:0] nb;
  logic        bump;
  logic [VAL_W-1:0] q0;
  logic [CNT_W-1:0] c0;
  logic [7:0]  tot;
  logic [VAL_W-1:0] bits;
  logic        hit;
  logic [IDX_W-1:0] hi;

  assign ofull = (ocnt_r == 2'd2);
  assign go = cmd_valid & ~ofull;
  assign cmd_take = go;
  assign e = cmd.idx;
  assign empty = (ocnt_r == 2'd0);
  assign res = oq_r[ord_r];

  // priority search for the first valid matching entry
  always_comb begin
    hit = 1'b0;
    hi = '0;
    for (int i = NE - 1; i >= 0; i--) begin
      if (kind_r[i] != KIND_NONE && src_r[i] == cmd.addr) begin
        hit = 1'b1;
        hi = IDX_W'(i);
      end
    end
  end

  // execute command
  always_comb begin
    r = '0;
    upd = 1'b0;
    wr_src = 1'b0;
    wr_tgt = 1'b0;
    nk = kind_r[e];
    nv = val_r[e];
    nb = bc_r[e];
    bump = 1'b0;
    q0 = (kind_r[e] == KIND_BITS) ? val_r[e] : '0;
    c0 = (kind_r[e] == KIND_BITS) ? bc_r[e] : '0;
    tot = {1'b0, c0} + {1'b0, cmd.n};
    bits = (cmd.n >= MAX_APPEND) ? {VAL_W{1'b1}} :
           (cmd.value & ((64'd1 << cmd.n[5:0]) - 64'd1));
    if (cmd.act) begin
      case (cmd.req)
        REQ_SET_SRC: begin
          upd = 1'b1; wr_src = 1'b1; nk = KIND_NONE; nv = '0; nb = '0; bump = 1'b1;
        end
        REQ_SET_TGT: begin
          upd = 1'b1; wr_tgt = 1'b1; nk = KIND_TAKEN; nv = '0; nb = '0; bump = 1'b1;
        end
        REQ_SET_COND: begin
          case (cmd.kind)
            COND_NONE: begin
              upd = 1'b1; nk = KIND_NONE; nv = '0; nb = '0; bump = 1'b1;
            end
            COND_TAKEN: begin
              upd = 1'b1; nk = KIND_TAKEN; nv = '0; nb = '0; bump = 1'b1;
            end
            COND_LOOP: begin
              upd = 1'b1; nk = KIND_LOOP; nv = cmd.value; nb = '0; bump = 1'b1;
            end
            COND_BITS: begin
              if (cmd.n == '0 || cmd.n > MAX_APPEND || tot > {1'b0, QUEUE_LIMIT}) begin
                r.err = 1'b1;
              end else begin
                upd = 1'b1;
                bump = (kind_r[e] != KIND_BITS);
                nk = KIND_BITS;
                nv = q0 | (bits << c0[5:0]);
                nb = tot[CNT_W-1:0];
              end
            end
            default: r.err = 1'b1;
          endcase
        end
        REQ_QUERY: begin
          if (hit) begin
            r.idx = hi;
            r.ver = VER_W'(ver_r[hi]);
            case (kind_r[hi])
              KIND_TAKEN: r.pred = PRED_TAKEN;
              KIND_LOOP:
                r.pred = val_r[hi][VAL_W-1] ? PRED_EXHAUSTED :
                         (val_r[hi] != '0 ? PRED_TAKEN : PRED_NOT_TAKEN);
              default:
                r.pred = (bc_r[hi] == '0) ? PRED_EXHAUSTED :
                         (val_r[hi][0] ? PRED_TAKEN : PRED_NOT_TAKEN);
            endcase
            if (r.pred == PRED_TAKEN) r.tgt = tgt_r[hi];
          end
        end
        REQ_CONSUME: begin
          if (kind_r[e] == KIND_LOOP && !val_r[e][VAL_W-1]) begin
            upd = 1'b1; nv = val_r[e] - 64'd1;
          end else if (kind_r[e] == KIND_BITS && bc_r[e] != '0) begin
            upd = 1'b1; nv = val_r[e] >> 1; nb = bc_r[e] - 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // entry table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NE; i++) begin
        src_r[i] <= '0;
        tgt_r[i] <= '0;
        kind_r[i] <= KIND_NONE;
        val_r[i] <= '0;
        bc_r[i] <= '0;
        ver_r[i] <= '0;
      end
    end else if (go && upd) begin
      if (wr_src) src_r[e] <= cmd.addr;
      if (wr_tgt) tgt_r[e] <= cmd.addr;
      kind_r[e] <= nk;
      val_r[e] <= nv;
      bc_r[e] <= nb;
      if (bump) ver_r[e] <= ver_r[e] + 1'b1;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= '0;
      ord_r <= 1'b0;
      owr_r <= 1'b0;
    end else begin
      ocnt_r <= ocnt_r + {1'b0, go} - {1'b0, pop & ~empty};
      ord_r <= ord_r ^ (pop & ~empty);
      owr_r <= owr_r ^ go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) oq_r[owr_r] <= r;
  end

  `PBT_ASSERT(a_no_take_full, ofull, !cmd_take, "command taken while result queue full")
  `PBT_ASSERT(a_cnt_range, 1'b1, ocnt_r <= 2'd2, "result count out of range")
  `PBT_ASSERT_NEXT(a_go_fills, go && !(pop && !empty), !empty, "result lost")
  `PBT_ASSERT(a_err_only_cond, go && r.err, cmd.req == REQ_SET_COND, "error on other request")

endmodule
